// ===== rtl/wfg_pkg.sv =====
// shared types, constants and helpers for the wait-for graph cycle detector
`timescale 1ns / 1ps

package wfg_pkg;

    // graph size and derived widths
    localparam int MAX_PROCESSES = 16;
    localparam int NODE_W        = $clog2(MAX_PROCESSES);
    localparam int COUNT_W       = $clog2(MAX_PROCESSES + 1);

    // width of the process_count register and of the id fields
    localparam int CFG_W = 5;
    localparam int ID_W  = 4;

    typedef logic [MAX_PROCESSES-1:0] node_set_t;
    typedef logic [NODE_W-1:0]        node_id_t;
    typedef logic [COUNT_W-1:0]       node_count_t;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DETECT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // search sequencer states
    typedef enum logic [1:0] {
        SRCH_IDLE,
        SRCH_ROOT,
        SRCH_STEP
    } srch_state_t;

    // write command into the adjacency matrix
    typedef struct packed {
        logic     add;
        logic     clear;
        node_id_t waiter;
        node_id_t holder;
    } mat_cmd_t;

    // search start and completion between the top level and the engine
    typedef struct packed {
        logic start;
    } srch_ctrl_t;

    typedef struct packed {
        logic done;
        logic found;
    } srch_stat_t;

    // process_count clamped to the graph size
    function automatic node_count_t active_count(input logic [CFG_W-1:0] count);
        logic [CFG_W-1:0] limit;
        limit = CFG_W'(MAX_PROCESSES);
        if (count > limit)
            return COUNT_W'(MAX_PROCESSES);
        return COUNT_W'(count);
    endfunction

    // one bit for each node below the active count
    function automatic node_set_t node_mask(input node_count_t n);
        node_set_t m;
        for (int i = 0; i < MAX_PROCESSES; i++)
            m[i] = (COUNT_W'(i) < n);
        return m;
    endfunction

    // index of the lowest set bit, zero for an empty set
    function automatic node_id_t lowest_bit(input node_set_t v);
        node_id_t idx;
        idx = '0;
        for (int i = MAX_PROCESSES - 1; i >= 0; i--)
            if (v[i])
                idx = NODE_W'(i);
        return idx;
    endfunction

endpackage

// ===== rtl/wfg_matrix.sv =====
// adjacency bit matrix of the wait-for graph with one row read port
`timescale 1ns / 1ps

module wfg_matrix (
    input  logic              clk,
    input  logic              rst_n,
    input  wfg_pkg::mat_cmd_t cmd,
    input  wfg_pkg::node_id_t rd_index,
    output wfg_pkg::node_set_t rd_row
);

    wfg_pkg::node_set_t rows_reg [wfg_pkg::MAX_PROCESSES];

    // clear wipes every row, add sets one bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wfg_pkg::MAX_PROCESSES; i++)
                rows_reg[i] <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < wfg_pkg::MAX_PROCESSES; i++)
                rows_reg[i] <= '0;
        end
        else if (cmd.add)
        begin
            rows_reg[cmd.waiter][cmd.holder] <= 1'b1;
        end
    end

    // row of the node on top of the search path
    assign rd_row = rows_reg[rd_index];

endmodule

// ===== rtl/wfg_search.sv =====
// depth-first search sequencer with explicit path stack and mark vectors
`timescale 1ns / 1ps

module wfg_search (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wfg_pkg::srch_ctrl_t    ctrl,
    input  wfg_pkg::node_count_t   node_count,
    input  wfg_pkg::node_set_t     row,
    output wfg_pkg::node_id_t      row_index,
    output wfg_pkg::srch_stat_t    stat
);

    wfg_pkg::srch_state_t  state_reg,   state_next;
    wfg_pkg::node_count_t  root_reg,    root_next;
    wfg_pkg::node_count_t  depth_reg,   depth_next;
    wfg_pkg::node_set_t    visited_reg, visited_next;
    wfg_pkg::node_set_t    onpath_reg,  onpath_next;

    wfg_pkg::node_id_t     stack_mem [wfg_pkg::MAX_PROCESSES];

    logic                  push;
    wfg_pkg::node_id_t     push_index;
    wfg_pkg::node_id_t     push_node;

    wfg_pkg::node_count_t  depth_m1;
    wfg_pkg::node_id_t     top;
    wfg_pkg::node_id_t     root_id;
    wfg_pkg::node_set_t    mask;
    wfg_pkg::node_set_t    live_row;
    wfg_pkg::node_set_t    fresh;
    wfg_pkg::node_id_t     next_node;

    // current top of the path and the edges out of it
    assign depth_m1  = depth_reg - wfg_pkg::COUNT_W'(1);
    assign top       = stack_mem[depth_m1[wfg_pkg::NODE_W-1:0]];
    assign row_index = top;
    assign root_id   = root_reg[wfg_pkg::NODE_W-1:0];
    assign mask      = wfg_pkg::node_mask(node_count);
    assign live_row  = row & mask;
    assign fresh     = live_row & ~visited_reg;
    assign next_node = wfg_pkg::lowest_bit(fresh);

    // state and mark registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wfg_pkg::SRCH_IDLE;
            root_reg    <= '0;
            depth_reg   <= '0;
            visited_reg <= '0;
            onpath_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            root_reg    <= root_next;
            depth_reg   <= depth_next;
            visited_reg <= visited_next;
            onpath_reg  <= onpath_next;
        end
    end

    // path stack, every entry written before it is read
    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[push_index] <= push_node;
    end

    // sequencer: one root check, push or pop a cycle
    always_comb
    begin
        state_next   = state_reg;
        root_next    = root_reg;
        depth_next   = depth_reg;
        visited_next = visited_reg;
        onpath_next  = onpath_reg;
        push         = 1'b0;
        push_index   = '0;
        push_node    = '0;
        stat.done    = 1'b0;
        stat.found   = 1'b0;

        unique case (state_reg)
            wfg_pkg::SRCH_IDLE:
            begin
                if (ctrl.start)
                begin
                    root_next    = '0;
                    depth_next   = '0;
                    visited_next = '0;
                    onpath_next  = '0;
                    state_next   = wfg_pkg::SRCH_ROOT;
                end
            end

            wfg_pkg::SRCH_ROOT:
            begin
                if (root_reg >= node_count)
                begin
                    stat.done  = 1'b1;
                    state_next = wfg_pkg::SRCH_IDLE;
                end
                else if (visited_reg[root_id])
                begin
                    root_next = root_reg + wfg_pkg::COUNT_W'(1);
                end
                else
                begin
                    visited_next[root_id] = 1'b1;
                    onpath_next[root_id]  = 1'b1;
                    push                  = 1'b1;
                    push_index            = '0;
                    push_node             = root_id;
                    depth_next            = wfg_pkg::COUNT_W'(1);
                    state_next            = wfg_pkg::SRCH_STEP;
                end
            end

            wfg_pkg::SRCH_STEP:
            begin
                if ((live_row & onpath_reg) != '0)
                begin
                    // an edge back onto the current path closes a cycle
                    stat.done  = 1'b1;
                    stat.found = 1'b1;
                    state_next = wfg_pkg::SRCH_IDLE;
                end
                else if (fresh != '0
                         && depth_reg != wfg_pkg::COUNT_W'(wfg_pkg::MAX_PROCESSES))
                begin
                    visited_next[next_node] = 1'b1;
                    onpath_next[next_node]  = 1'b1;
                    push                    = 1'b1;
                    push_index              = depth_reg[wfg_pkg::NODE_W-1:0];
                    push_node               = next_node;
                    depth_next              = depth_reg + wfg_pkg::COUNT_W'(1);
                end
                else
                begin
                    // dead end, back up one level
                    onpath_next[top] = 1'b0;
                    depth_next       = depth_m1;
                    if (depth_reg == wfg_pkg::COUNT_W'(1))
                    begin
                        root_next  = root_reg + wfg_pkg::COUNT_W'(1);
                        state_next = wfg_pkg::SRCH_ROOT;
                    end
                end
            end

            default:
            begin
                state_next = wfg_pkg::SRCH_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/wait_for_graph_cycle_detect.sv =====
// top level of the wait-for graph cycle detector
`timescale 1ns / 1ps

// Holds a wait-for graph of up to 16 processes as an adjacency bit matrix and
// answers one item with one result. Add and clear items take effect at the edge
// that accepts them, and that same edge registers their result. A detect item
// runs a depth-first search in a single sequencer that does one root check,
// push or pop per cycle, with one matrix row read and one lowest-bit pick in
// each. Its result is registered in the output register when the search ends,
// and in_ready stays low meanwhile. A found cycle ends the search early. The
// input side is ready again as soon as the output register is empty or being
// emptied, so a new item may enter while the result is taken. process_count
// above 16 acts as 16; the user must write it through cfg_valid/cfg_data only
// while the block is idle, as the block itself does not enforce this.

module wait_for_graph_cycle_detect (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   operation,
    input  logic [wfg_pkg::ID_W-1:0]     waiter,
    input  logic [wfg_pkg::ID_W-1:0]     holder,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         deadlock,
    output logic                         status,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [wfg_pkg::CFG_W-1:0]    cfg_data
);

    logic [wfg_pkg::CFG_W-1:0] count_reg;
    logic                      busy_reg, busy_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      deadlock_reg, deadlock_next;
    logic                      status_reg, status_next;

    wfg_pkg::node_count_t      node_count;
    wfg_pkg::mat_cmd_t         mat_cmd;
    wfg_pkg::srch_ctrl_t       srch_ctrl;
    wfg_pkg::srch_stat_t       srch_stat;
    wfg_pkg::node_id_t         row_index;
    wfg_pkg::node_set_t        row;

    logic                      accept;
    logic                      in_range;
    wfg_pkg::op_t              op;

    assign node_count = wfg_pkg::active_count(count_reg);
    assign op         = wfg_pkg::op_t'(operation);
    assign in_ready   = !busy_reg && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign in_range   = (wfg_pkg::COUNT_W'(waiter) < node_count)
                        && (wfg_pkg::COUNT_W'(holder) < node_count);
    assign cfg_ready  = 1'b1;

    assign out_valid  = out_valid_reg;
    assign deadlock   = deadlock_reg;
    assign status     = status_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= wfg_pkg::CFG_W'(wfg_pkg::MAX_PROCESSES);
        else if (cfg_valid && cfg_ready)
            count_reg <= cfg_data;
    end

    // decode of the accepted item
    always_comb
    begin
        mat_cmd.add     = 1'b0;
        mat_cmd.clear   = 1'b0;
        mat_cmd.waiter  = waiter;
        mat_cmd.holder  = holder;
        srch_ctrl.start = 1'b0;
        busy_next       = busy_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        deadlock_next   = deadlock_reg;
        status_next     = status_reg;

        if (busy_reg && srch_stat.done)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            deadlock_next  = srch_stat.found;
            status_next    = 1'b0;
        end

        if (accept)
        begin
            unique case (op)
                wfg_pkg::OP_ADD:
                begin
                    mat_cmd.add    = in_range;
                    out_valid_next = 1'b1;
                    deadlock_next  = 1'b0;
                    status_next    = !in_range;
                end
                wfg_pkg::OP_DETECT:
                begin
                    srch_ctrl.start = 1'b1;
                    busy_next       = 1'b1;
                end
                wfg_pkg::OP_CLEAR:
                begin
                    mat_cmd.clear  = 1'b1;
                    out_valid_next = 1'b1;
                    deadlock_next  = 1'b0;
                    status_next    = 1'b0;
                end
                default:
                begin
                    out_valid_next = 1'b1;
                    deadlock_next  = 1'b0;
                    status_next    = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        deadlock_reg <= deadlock_next;
        status_reg   <= status_next;
    end

    wfg_matrix u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (mat_cmd),
        .rd_index (row_index),
        .rd_row   (row)
    );

    wfg_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (srch_ctrl),
        .node_count (node_count),
        .row        (row),
        .row_index  (row_index),
        .stat       (srch_stat)
    );

endmodule

// ===== bench/tb_wait_for_graph_cycle_detect.sv =====
// self-checking testbench for the wait-for graph cycle detector
`timescale 1ns / 1ps

module tb_wait_for_graph_cycle_detect;

    // one request into the detector
    typedef struct packed {
        wfg_pkg::op_t     op;
        wfg_pkg::node_id_t waiter;
        wfg_pkg::node_id_t holder;
    } wait_req_t;

    // one answer out of the detector
    typedef struct packed {
        logic deadlock;
        logic status;
    } verdict_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [1:0]                operation = '0;
    logic [wfg_pkg::ID_W-1:0]  waiter = '0;
    logic [wfg_pkg::ID_W-1:0]  holder = '0;

    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      deadlock;
    logic                      status;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [wfg_pkg::CFG_W-1:0] cfg_data = '0;

    // requests waiting to be driven and verdicts waiting to come back
    wait_req_t request_q[$];
    verdict_t  verdict_q[$];

    // shadow copy of the graph and the count register
    wfg_pkg::node_set_t        wait_rows[wfg_pkg::MAX_PROCESSES];
    logic [wfg_pkg::CFG_W-1:0] proc_count = 5'd16;

    // random idling, percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    logic in_taken = 1'b0;
    int   n_queued = 0;
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_detects = 0;
    int   n_deadlocks = 0;
    int   n_flagged = 0;
    int   n_cfg_writes = 0;

    wait_for_graph_cycle_detect u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .waiter    (waiter),
        .holder    (holder),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .deadlock  (deadlock),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always #4 clk = ~clk;

    // effective number of processes
    function automatic int live_count();
        return (proc_count > 5'd16) ? wfg_pkg::MAX_PROCESSES : int'(proc_count);
    endfunction

    // depth-first search over the shadow graph with an explicit path stack
    function automatic logic graph_has_cycle();
        int                 n;
        int                 depth;
        int                 top;
        int                 nxt;
        int                 path_nodes[wfg_pkg::MAX_PROCESSES];
        wfg_pkg::node_set_t live;
        wfg_pkg::node_set_t seen;
        wfg_pkg::node_set_t on_path;
        wfg_pkg::node_set_t row;
        wfg_pkg::node_set_t fresh;
        n = live_count();
        live = '0;
        for (int i = 0; i < n; i++)
            live[i] = 1'b1;
        seen = '0;
        on_path = '0;
        for (int r = 0; r < n; r++)
        begin
            if (seen[r])
                continue;
            seen[r] = 1'b1;
            on_path[r] = 1'b1;
            path_nodes[0] = r;
            depth = 1;
            while (depth > 0)
            begin
                top = path_nodes[depth-1];
                row = wait_rows[top] & live;
                if ((row & on_path) != '0)
                    return 1'b1;
                fresh = row & ~seen;
                if (fresh != '0 && depth < wfg_pkg::MAX_PROCESSES)
                begin
                    nxt = 0;
                    while (!fresh[nxt])
                        nxt++;
                    seen[nxt] = 1'b1;
                    on_path[nxt] = 1'b1;
                    path_nodes[depth] = nxt;
                    depth++;
                end
                else
                begin
                    on_path[top] = 1'b0;
                    depth--;
                end
            end
        end
        return 1'b0;
    endfunction

    // apply one request to the shadow graph and work out its verdict
    function automatic verdict_t apply_request(input wait_req_t req);
        verdict_t v;
        int       n;
        v = '0;
        n = live_count();
        case (req.op)
            wfg_pkg::OP_ADD:
            begin
                if (int'(req.waiter) < n && int'(req.holder) < n)
                    wait_rows[req.waiter][req.holder] = 1'b1;
                else
                    v.status = 1'b1;
            end
            wfg_pkg::OP_DETECT:
                v.deadlock = graph_has_cycle();
            wfg_pkg::OP_CLEAR:
                for (int i = 0; i < wfg_pkg::MAX_PROCESSES; i++)
                    wait_rows[i] = '0;
            default:
                v = '0;
        endcase
        return v;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
        end
    endfunction

    // driver: requests and receiver stalls change at the falling edge
    always @(negedge clk)
    begin
        wait_req_t cur;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur = request_q.pop_front();
                    in_valid  <= 1'b1;
                    operation <= cur.op;
                    waiter    <= cur.waiter;
                    holder    <= cur.holder;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        wait_req_t req;
        verdict_t  want;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                req.op     = wfg_pkg::op_t'(operation);
                req.waiter = waiter;
                req.holder = holder;
                want = apply_request(req);
                if (req.op == wfg_pkg::OP_DETECT)
                    n_detects++;
                if (want.deadlock)
                    n_deadlocks++;
                if (want.status)
                    n_flagged++;
                verdict_q = {verdict_q, want};
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: result with nothing expected, deadlock=%0b status=%0b",
                                 $time, deadlock, status);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("deadlock", want.deadlock, deadlock);
                    check_field("status", want.status, status);
                    n_checked++;
                end
            end
        end
    end

    task automatic queue_request(input wfg_pkg::op_t op, input int w, input int h);
        wait_req_t req;
        req.op     = op;
        req.waiter = wfg_pkg::node_id_t'(w);
        req.holder = wfg_pkg::node_id_t'(h);
        request_q = {request_q, req};
        if (op != wfg_pkg::OP_NONE)
            n_queued++;
    endtask

    // hold off until the block has answered everything sent so far
    task automatic wait_drained();
        @(posedge clk);
        while (request_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_count(input logic [wfg_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        proc_count = value;
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // clear, build a graph of random, acyclic or acyclic-plus-back-edge shape, detect
    task automatic queue_graph_round();
        int eff;
        int kind;
        int edges;
        int a;
        int b;
        eff = live_count();
        if (eff == 0)
        begin
            queue_request(wfg_pkg::OP_DETECT, $urandom_range(15), $urandom_range(15));
            return;
        end
        queue_request(wfg_pkg::OP_CLEAR, $urandom_range(15), $urandom_range(15));
        kind = (eff < 2) ? 0 : $urandom_range(2);
        edges = $urandom_range(eff + 2, 1);
        a = 0;
        b = 0;
        for (int i = 0; i < edges; i++)
        begin
            if (kind == 0)
            begin
                a = $urandom_range(eff - 1);
                b = $urandom_range(eff - 1);
            end
            else
            begin
                a = $urandom_range(eff - 2);
                b = $urandom_range(eff - 1, a + 1);
            end
            queue_request(wfg_pkg::OP_ADD, a, b);
            if ($urandom_range(99) < 12)
                queue_request(wfg_pkg::OP_DETECT, $urandom_range(15), $urandom_range(15));
        end
        // close a two-node loop on the last edge
        if (kind == 2)
            queue_request(wfg_pkg::OP_ADD, b, a);
        // an edge that touches an unused process
        if (eff < wfg_pkg::MAX_PROCESSES && $urandom_range(99) < 15)
            queue_request(wfg_pkg::OP_ADD, $urandom_range(15, eff), $urandom_range(15));
        queue_request(wfg_pkg::OP_DETECT, $urandom_range(15), $urandom_range(15));
    endtask

    task automatic queue_random(input int target);
        int start;
        start = n_queued;
        while (n_queued - start < target)
        begin
            if ($urandom_range(99) < 75)
                queue_graph_round();
            else
                queue_request(wfg_pkg::op_t'($urandom_range(3)), $urandom_range(15),
                              $urandom_range(15));
        end
    endtask

    task automatic run_phase(input logic [wfg_pkg::CFG_W-1:0] count,
                             input int unsigned send_pct,
                             input int unsigned recv_pct, input int target);
        wait_drained();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        write_count(count);
        queue_random(target);
    endtask

    // stimulus
    initial
    begin
        for (int i = 0; i < wfg_pkg::MAX_PROCESSES; i++)
            wait_rows[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extreme ids, duplicates, self wait, unused op, clear
        queue_request(wfg_pkg::OP_DETECT, 0, 0);
        queue_request(wfg_pkg::OP_ADD, 0, 15);
        queue_request(wfg_pkg::OP_ADD, 0, 15);
        queue_request(wfg_pkg::OP_DETECT, 15, 15);
        queue_request(wfg_pkg::OP_ADD, 15, 0);
        queue_request(wfg_pkg::OP_DETECT, 0, 0);
        queue_request(wfg_pkg::OP_NONE, 15, 15);
        queue_request(wfg_pkg::OP_CLEAR, 15, 15);
        queue_request(wfg_pkg::OP_DETECT, 0, 0);
        queue_request(wfg_pkg::OP_ADD, 7, 7);
        queue_request(wfg_pkg::OP_DETECT, 0, 0);
        queue_request(wfg_pkg::OP_CLEAR, 0, 0);
        queue_request(wfg_pkg::OP_ADD, 10, 11);
        queue_request(wfg_pkg::OP_ADD, 11, 10);

        // count lowered under stored edges, then ids out of range
        wait_drained();
        write_count(5'd4);
        queue_request(wfg_pkg::OP_DETECT, 0, 0);
        queue_request(wfg_pkg::OP_ADD, 4, 3);
        queue_request(wfg_pkg::OP_ADD, 2, 12);
        wait_drained();
        write_count(5'd16);
        queue_request(wfg_pkg::OP_DETECT, 0, 0);

        // count of zero
        wait_drained();
        write_count(5'd0);
        queue_request(wfg_pkg::OP_ADD, 0, 0);
        queue_request(wfg_pkg::OP_DETECT, 0, 0);

        // count above the maximum
        wait_drained();
        write_count(5'd31);
        queue_request(wfg_pkg::OP_ADD, 15, 14);
        queue_request(wfg_pkg::OP_ADD, 14, 15);
        queue_request(wfg_pkg::OP_DETECT, 0, 0);
        queue_request(wfg_pkg::OP_CLEAR, 0, 0);

        // random phases over counts and idling patterns
        run_phase(5'd5, 0, 0, 300);
        run_phase(5'd16, 83, 0, 150);
        wait_drained();
        queue_random(150);
        run_phase(5'd1, 0, 83, 150);
        run_phase(5'd17, 0, 83, 300);
        run_phase(5'd9, 33, 33, 350);
        run_phase(5'($urandom_range(15, 2)), 0, 0, 350);

        wait_drained();
        repeat (64) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            n_errors++;
            $display("%0d results never arrived", verdict_q.size());
        end
        $display("Checked %0d results over %0d count settings: %0d detects, %0d deadlocks found,",
                 n_checked, n_cfg_writes, n_detects, n_deadlocks);
        $display("%0d edges flagged out of range, %0d mismatches", n_flagged, n_errors);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("Timed out with %0d results outstanding", verdict_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wfg_pkg.sv
rtl/wfg_matrix.sv
rtl/wfg_search.sv
rtl/wait_for_graph_cycle_detect.sv
bench/tb_wait_for_graph_cycle_detect.sv
